@@ src/dopt_pkg.sv @@
// Shared types and constants for the deadline ordered priority table.
// No dependencies; used by every other file of the block.
package dopt_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam int ID_W   = 8;
   localparam int REL_W  = 16;
   localparam int NOW_W  = 31;
   localparam int DL_W   = 32;
   localparam int PRIO_W = 4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic accept;
      logic sort_pass;
      logic sort_odd;
      logic rotate;
      logic emit;
      logic reject;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_valid;
      logic out_free;
   } status_type;

endpackage

@@ src/dopt_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on dopt_pkg for field widths.
interface dopt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [dopt_pkg::ID_W-1:0]  task_id;
   logic [dopt_pkg::REL_W-1:0] lead_time;
   logic [dopt_pkg::NOW_W-1:0] current_time;

   modport source (output valid, op, task_id, lead_time, current_time, input ready);
   modport sink (input valid, op, task_id, lead_time, current_time, output ready);
endinterface

interface dopt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dopt_pkg::ID_W-1:0]   out_task_id;
   logic [dopt_pkg::PRIO_W-1:0] priority_res;
   logic                        status;
   logic                        last;

   modport source (output valid, out_task_id, priority_res, status, last, input ready);
   modport sink (input valid, out_task_id, priority_res, status, last, output ready);
endinterface

@@ src/deadline_ordered_priority_table_unit.sv @@
// Top level of the deadline ordered priority table.
// Depends on dopt_pkg, dopt_if, dopt_ctrl and dopt_datapath.
//
// Usage:
//   req_ch carries one transaction per task event: op insert adds task_id with
//   deadline current_time + lead_time, op remove frees the first entry that
//   holds task_id (no response). rsp_ch returns, after each insert, every
//   occupied entry ordered latest deadline first with priority_res = position + 1,
//   last set on the final one. An insert into a full table returns a single
//   response with status full, priority_res 0 and last set.
// Sequence:
//   req_ch.ready is high only while the sequencer is idle. A remove is done
//   at its accept and the sequencer stays idle. An insert runs an accept,
//   DEPTH odd-even compare-exchange passes and DEPTH rotations of the slot
//   row; a rejected insert runs an accept and then a reject step.
// Reset empties the table and drops any pending response. When rsp_ch stalls,
//   the response register holds and the rotation waits on occupied slots.
module deadline_ordered_priority_table_unit #(
   parameter int DEPTH = dopt_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   dopt_req_if.sink    req_ch,
   dopt_rsp_if.source  rsp_ch
);

   dopt_pkg::cmd_type          cmd;
   dopt_pkg::status_type       status;
   logic [$clog2(DEPTH)-1:0]   step;
   logic                       ready;

   assign req_ch.ready = ready;

   dopt_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd),
      .step      (step)
   );

   dopt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_ch.op),
      .req_task_id       (req_ch.task_id),
      .req_lead_time     (req_ch.lead_time),
      .req_current_time  (req_ch.current_time),
      .cmd               (cmd),
      .step              (step),
      .status            (status),
      .rsp_ch            (rsp_ch)
   );

endmodule

@@ src/dopt_ctrl.sv @@
// Sequencer for accept, sort passes, emission rotation and reject.
// Depends on dopt_pkg for command and status types.
module dopt_ctrl #(
   parameter int DEPTH = dopt_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  dopt_pkg::status_type status,
   output dopt_pkg::cmd_type    cmd,
   output logic [$clog2(DEPTH)-1:0] step
);

   localparam int CW = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SORT   = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_REJECT = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   step_ff, step_in;
   logic            step_end;

   assign step_end = (step_ff == CW'(DEPTH - 1));
   assign step     = step_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == dopt_pkg::OP_INSERT) begin
                  step_in  = '0;
                  state_in = status.full ? ST_REJECT : ST_SORT;
               end
            end
         end
         ST_SORT: begin
            cmd.sort_pass = 1'b1;
            cmd.sort_odd  = step_ff[0];
            if (step_end) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit   = status.head_valid & status.out_free;
            cmd.rotate = ~status.head_valid | status.out_free;
            if (cmd.rotate) begin
               if (step_end) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_REJECT: begin
            if (status.out_free) begin
               cmd.reject = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ src/dopt_datapath.sv @@
// Task table slots, compare-exchange network, rotation and response register.
// Depends on dopt_pkg and the channel interfaces in dopt_if.
module dopt_datapath #(
   parameter int DEPTH = dopt_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_op,
   input  logic [dopt_pkg::ID_W-1:0]  req_task_id,
   input  logic [dopt_pkg::REL_W-1:0] req_lead_time,
   input  logic [dopt_pkg::NOW_W-1:0] req_current_time,
   input  dopt_pkg::cmd_type         cmd,
   input  logic [$clog2(DEPTH)-1:0]  step,
   output dopt_pkg::status_type      status,
   dopt_rsp_if.source                rsp_ch
);

   localparam int CW = $clog2(DEPTH);

   logic [dopt_pkg::ID_W-1:0] id_ff [DEPTH];
   logic [dopt_pkg::ID_W-1:0] id_in [DEPTH];
   logic [dopt_pkg::DL_W-1:0] dl_ff [DEPTH];
   logic [dopt_pkg::DL_W-1:0] dl_in [DEPTH];
   logic [DEPTH-1:0]          vld_ff, vld_in;

   logic [DEPTH-1:0] free_vec, match_vec, ins_mask, rm_mask;
   logic [DEPTH-1:0] take_next, take_prev;
   logic [DEPTH-2:0] swap_b;
   logic [dopt_pkg::DL_W-1:0] new_dl;
   logic                      do_insert, do_remove;

   logic [dopt_pkg::ID_W-1:0]   rej_id_ff;
   logic                        out_valid_ff;
   logic [dopt_pkg::ID_W-1:0]   out_id_ff;
   logic [dopt_pkg::PRIO_W-1:0] out_prio_ff;
   logic                        out_status_ff;
   logic                        out_last_ff;
   logic [CW:0]                 pos1;
   logic                        out_free;

   assign new_dl    = dopt_pkg::DL_W'(req_current_time) + dopt_pkg::DL_W'(req_lead_time);
   assign do_insert = cmd.accept & (req_op == dopt_pkg::OP_INSERT);
   assign do_remove = cmd.accept & (req_op == dopt_pkg::OP_REMOVE);

   assign free_vec = ~vld_ff;
   assign ins_mask = free_vec & (~free_vec + DEPTH'(1));
   assign rm_mask  = match_vec & (~match_vec + DEPTH'(1));

   genvar p, i;
   generate
      for (p = 0; p < DEPTH - 1; p++) begin : g_pair
         assign swap_b[p] = cmd.sort_pass && (cmd.sort_odd == 1'(p % 2)) &&
                            ((vld_ff[p+1] && !vld_ff[p]) ||
                             (vld_ff[p+1] && vld_ff[p] && (dl_ff[p+1] > dl_ff[p])));
      end

      for (i = 0; i < DEPTH; i++) begin : g_slot
         localparam int NXT = (i + 1) % DEPTH;
         localparam int PRV = (i + DEPTH - 1) % DEPTH;

         assign match_vec[i] = vld_ff[i] && (id_ff[i] == req_task_id);

         if (i < DEPTH - 1) begin : g_hi
            assign take_next[i] = swap_b[i];
         end else begin : g_hi_end
            assign take_next[i] = 1'b0;
         end
         if (i > 0) begin : g_lo
            assign take_prev[i] = swap_b[i-1];
         end else begin : g_lo_end
            assign take_prev[i] = 1'b0;
         end

         always_comb begin
            id_in[i]  = id_ff[i];
            dl_in[i]  = dl_ff[i];
            vld_in[i] = vld_ff[i];
            if (do_insert && ins_mask[i]) begin
               id_in[i]  = req_task_id;
               dl_in[i]  = new_dl;
               vld_in[i] = 1'b1;
            end
            if (do_remove && rm_mask[i]) begin
               vld_in[i] = 1'b0;
            end
            if (take_next[i] || cmd.rotate) begin
               id_in[i]  = id_ff[NXT];
               dl_in[i]  = dl_ff[NXT];
               vld_in[i] = vld_ff[NXT];
            end else if (take_prev[i]) begin
               id_in[i]  = id_ff[PRV];
               dl_in[i]  = dl_ff[PRV];
               vld_in[i] = vld_ff[PRV];
            end
         end

         always_ff @(posedge clock) begin
            id_ff[i] <= id_in[i];
            dl_ff[i] <= dl_in[i];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_free = ~out_valid_ff | rsp_ch.ready;
   assign pos1     = {1'b0, step} + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rej_id_ff <= req_task_id;
      end
      if (cmd.emit) begin
         out_id_ff     <= id_ff[0];
         out_prio_ff   <= dopt_pkg::PRIO_W'(pos1);
         out_status_ff <= dopt_pkg::STATUS_OK;
         out_last_ff   <= ~vld_ff[1] | (step == CW'(DEPTH - 1));
      end else if (cmd.reject) begin
         out_id_ff     <= rej_id_ff;
         out_prio_ff   <= '0;
         out_status_ff <= dopt_pkg::STATUS_FULL;
         out_last_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.reject) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_task_id  = out_id_ff;
   assign rsp_ch.priority_res = out_prio_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.last         = out_last_ff;

   assign status.full       = &vld_ff;
   assign status.head_valid = vld_ff[0];
   assign status.out_free   = out_free;

endmodule

@@ src/dopt_checker.sv @@
// Port-level checks of the deadline ordered priority table, bound to the top.
// Depends on dopt_pkg and deadline_ordered_priority_table_unit.
module dopt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dopt_pkg::ID_W-1:0]     rsp_out_task_id,
   input logic [dopt_pkg::PRIO_W-1:0]   rsp_priority_res,
   input logic                          rsp_status,
   input logic                          rsp_last
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_task_id) &&
      $stable(rsp_priority_res) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dopt_pkg::STATUS_FULL) |->
      (rsp_priority_res == '0) && rsp_last)
      else $error("rejected insert response malformed");

   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken while insert responses pending");

endmodule

bind deadline_ordered_priority_table_unit dopt_checker u_dopt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_task_id  (rsp_ch.out_task_id),
   .rsp_priority_res (rsp_ch.priority_res),
   .rsp_status       (rsp_ch.status),
   .rsp_last         (rsp_ch.last)
);

@@ tb/sv/tb_deadline_ordered_priority_table_unit.sv @@
// Self-checking testbench for deadline_ordered_priority_table_unit: predicts the
// deadline-ordered table and its priority responses for every accepted request.
// Depends on dopt_pkg, dopt_if and the unit under test; needs no other files.
module tb_deadline_ordered_priority_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = dopt_pkg::DEPTH_DEFAULT;
   localparam int ID_W       = dopt_pkg::ID_W;
   localparam int REL_W      = dopt_pkg::REL_W;
   localparam int NOW_W      = dopt_pkg::NOW_W;
   localparam int DL_W       = dopt_pkg::DL_W;
   localparam int PRIO_W     = dopt_pkg::PRIO_W;
   localparam int MAX_WAIT   = 19;
   localparam int IDLE_LIMIT = 2000;
   localparam int PRINT_CAP  = 60;

   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] prio;
      logic              status;
      logic              last;
   } priority_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dopt_req_if req_ch();
   dopt_rsp_if rsp_ch();

   deadline_ordered_priority_table_unit #(.DEPTH(DEPTH)) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   logic [ID_W-1:0] slot_id       [DEPTH];
   logic [DL_W-1:0] slot_deadline [DEPTH];
   logic            slot_used     [DEPTH] = '{default: 1'b0};

   priority_rsp_type priority_q[$];
   int               error_count = 0;
   int               idle_cycles = 0;
   bit               calm = 1'b0;

   task automatic flag_error(string msg);
      if (error_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit runs_ahead(int a, int b);
      if (slot_used[a] != slot_used[b]) return slot_used[a];
      if (!slot_used[a]) return 1'b0;
      return slot_deadline[a] > slot_deadline[b];
   endfunction

   function automatic bit id_present(logic [ID_W-1:0] id);
      foreach (slot_used[i]) if (slot_used[i] && slot_id[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int occupancy();
      int n;
      n = 0;
      foreach (slot_used[i]) n += slot_used[i];
      return n;
   endfunction

   function automatic void predict_priorities(logic op, logic [ID_W-1:0] id,
         logic [REL_W-1:0] rel, logic [NOW_W-1:0] now);
      int               free_slot;
      int               j;
      logic [ID_W-1:0]  t_id;
      logic [DL_W-1:0]  t_dl;
      logic             t_used;
      priority_rsp_type r;
      if (op == dopt_pkg::OP_REMOVE) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (slot_used[i] && slot_id[i] == id) begin
               slot_used[i] = 1'b0;
               return;
            end
         end
         return;
      end
      free_slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
      if (free_slot < 0) begin
         r.task_id = id;
         r.prio    = '0;
         r.status  = dopt_pkg::STATUS_FULL;
         r.last    = 1'b1;
         priority_q.push_back(r);
         return;
      end
      slot_id[free_slot]       = id;
      slot_deadline[free_slot] = DL_W'(now) + DL_W'(rel);
      slot_used[free_slot]     = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         j = i;
         while (j > 0 && runs_ahead(j, j - 1)) begin
            t_id   = slot_id[j];
            t_dl   = slot_deadline[j];
            t_used = slot_used[j];
            slot_id[j]           = slot_id[j-1];
            slot_deadline[j]     = slot_deadline[j-1];
            slot_used[j]         = slot_used[j-1];
            slot_id[j-1]         = t_id;
            slot_deadline[j-1]   = t_dl;
            slot_used[j-1]       = t_used;
            j--;
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (!slot_used[i]) break;
         r.task_id = slot_id[i];
         r.prio    = PRIO_W'(i + 1);
         r.status  = dopt_pkg::STATUS_OK;
         r.last    = 1'b0;
         priority_q.push_back(r);
      end
      priority_q[priority_q.size()-1].last = 1'b1;
   endfunction

   task automatic send_task_event(logic op, logic [ID_W-1:0] id,
         logic [REL_W-1:0] rel, logic [NOW_W-1:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.task_id      <= id;
      req_ch.lead_time    <= rel;
      req_ch.current_time <= now;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_priorities(op, id, rel, now);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (priority_q.size() != 0);
   endtask

   task automatic test_fill_and_reject();
      send_task_event(dopt_pkg::OP_INSERT, 8'h00, 16'h0000, 31'h0000_0000);
      send_task_event(dopt_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF);
      send_task_event(dopt_pkg::OP_INSERT, 8'h10, 16'd100, 31'd1000);
      send_task_event(dopt_pkg::OP_INSERT, 8'h11, 16'd0, 31'd1100);
      send_task_event(dopt_pkg::OP_INSERT, 8'h10, 16'd50, 31'd1050);
      send_task_event(dopt_pkg::OP_INSERT, 8'hA5, 16'h5A5A, 31'h2AAA_AAAA);
      send_task_event(dopt_pkg::OP_INSERT, 8'h5A, 16'hA5A5, 31'h5555_5555);
      send_task_event(dopt_pkg::OP_INSERT, 8'h7F, 16'd1, 31'd0);
      send_task_event(dopt_pkg::OP_INSERT, 8'h80, 16'd7, 31'd7);
   endtask

   task automatic test_remove_cases();
      logic [ID_W-1:0] gone [7] = '{8'h00, 8'hFF, 8'h11, 8'hA5, 8'h5A, 8'h7F, 8'h33};
      send_task_event(dopt_pkg::OP_REMOVE, 8'h10, 16'hFFFF, 31'h7FFF_FFFF);
      send_task_event(dopt_pkg::OP_REMOVE, 8'h42, 16'h0000, 31'h0000_0000);
      send_task_event(dopt_pkg::OP_INSERT, 8'h33, 16'd2000, 31'd0);
      send_task_event(dopt_pkg::OP_REMOVE, 8'h10, 16'h0000, 31'h0000_0000);
      foreach (gone[i])
         send_task_event(dopt_pkg::OP_REMOVE, gone[i], 16'h0000, 31'h0000_0000);
      send_task_event(dopt_pkg::OP_REMOVE, 8'h33, 16'h0000, 31'h0000_0000);
      send_task_event(dopt_pkg::OP_INSERT, 8'h01, 16'd5, 31'd5);
   endtask

   task automatic test_random_traffic(int n_items);
      int               used;
      int               pick;
      int               k;
      int               counted;
      int               sent;
      logic             op;
      logic [ID_W-1:0]  id;
      logic [REL_W-1:0] rel;
      logic [NOW_W-1:0] now;
      logic [NOW_W-1:0] base;
      base    = NOW_W'($urandom);
      counted = 0;
      sent    = 0;
      while (counted < n_items) begin
         calm = ((sent / 40) % 4) == 2;
         used = occupancy();
         rel  = REL_W'($urandom);
         now  = NOW_W'($urandom);
         id   = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            op = dopt_pkg::OP_REMOVE;
         end else if (used > 0 && pick < 8 + 9 * used) begin
            op = dopt_pkg::OP_REMOVE;
            k  = $urandom_range(0, used - 1);
            foreach (slot_used[i]) begin
               if (slot_used[i]) begin
                  if (k == 0) id = slot_id[i];
                  k--;
               end
            end
         end else begin
            op = dopt_pkg::OP_INSERT;
            if ($urandom_range(0, 1) == 0) begin
               now = base + NOW_W'($urandom_range(0, 3));
               rel = REL_W'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 7) == 0) base = NOW_W'($urandom);
         end
         if (op == dopt_pkg::OP_INSERT || id_present(id)) counted++;
         sent++;
         send_task_event(op, id, rel, now);
         if (counted == n_items / 2 && op == dopt_pkg::OP_INSERT) wait_for_results();
      end
      calm = 1'b0;
   endtask

   initial begin : rsp_sink
      int               stall;
      priority_rsp_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         if (priority_q.size() == 0) begin
            flag_error($sformatf("unexpected response task_id %0d priority %0d",
                                 rsp_ch.out_task_id, rsp_ch.priority_res));
         end else begin
            want = priority_q.pop_front();
            if (rsp_ch.out_task_id !== want.task_id)
               flag_error($sformatf("out_task_id %0d, expected %0d",
                                    rsp_ch.out_task_id, want.task_id));
            if (rsp_ch.priority_res !== want.prio)
               flag_error($sformatf("priority_res %0d, expected %0d (task_id %0d)",
                                    rsp_ch.priority_res, want.prio, want.task_id));
            if (rsp_ch.status !== want.status)
               flag_error($sformatf("status %0b, expected %0b (task_id %0d)",
                                    rsp_ch.status, want.status, want.task_id));
            if (rsp_ch.last !== want.last)
               flag_error($sformatf("last %0b, expected %0b (task_id %0d)",
                                    rsp_ch.last, want.last, want.task_id));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_deadline_ordered_priority_table_unit failed");
         $finish;
      end
   end

   initial begin : main
      req_ch.valid        <= 1'b0;
      req_ch.op           <= dopt_pkg::OP_INSERT;
      req_ch.task_id      <= '0;
      req_ch.lead_time    <= '0;
      req_ch.current_time <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_fill_and_reject();
      wait_for_results();
      test_remove_cases();
      wait_for_results();
      test_random_traffic(130);
      wait_for_results();
      calm = 1'b1;
      repeat (4 * DEPTH + 40) @(posedge clock);
      if (priority_q.size() != 0)
         flag_error($sformatf("%0d responses never arrived", priority_q.size()));
      if (error_count == 0) begin
         $display("tb_deadline_ordered_priority_table_unit passed");
      end else begin
         $display("tb_deadline_ordered_priority_table_unit failed");
      end
      $finish;
   end

endmodule
